@@ src/assert_macros.svh @@
// Assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MLK_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define MLK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define MLK_ASSERT(lbl, expr, msg)
`define MLK_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

@@ src/mlk_pkg.sv @@
package mlk_pkg;

  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam int unsigned N_MAX       = 40;
  localparam int unsigned DIV_STAGES  = 64;
  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned NBITS       = 6;
  localparam int unsigned TAYLOR_ORD  = 10;
  localparam int unsigned RECIP_SH    = 35;
  localparam logic [15:0] SCALE_RST   = 16'd256;
  // first x (distance/2 in Q.32) whose exponent exceeds N_MAX
  localparam logic [46:0] X_BIG       = 47'(64'(N_MAX + 1) * 64'(LN2_Q32));

  typedef struct packed {
    logic [31:0]        r;
    logic signed [33:0] sum;
    logic [5:0]         n;
    logic [31:0]        dval;
    logic               sing;
    logic               big;
  } tk_pay_t;

endpackage

@@ src/mahalanobis_likelihood_2d.sv @@
// Throughput: one item per cycle; a stall on out_tready freezes the whole pipe.
// Depth is set by the divider (one quotient bit per stage, 64 stages), the square
// root (one result bit per stage, 32 stages) and the exp series (3 stages a term).
// Reset (rst_n low, synchronous): pipe emptied, scale register back to 256 (1.0).
`include "assert_macros.svh"
module mahalanobis_likelihood_2d (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pred_x, pred_y, meas_x, meas_y, cov_xx, cov_xy, cov_yx, cov_yy (32 bits each)
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // distance [31:0], likelihood [47:32]
  output logic [47:0]  out_tdata,
  // singular [0]
  output logic [0:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  logic adv;
  logic [15:0] gain_r;

  logic out_vld_r;
  logic [31:0] out_dist_r;
  logic [15:0] out_lik_r;
  logic out_sing_r;

  assign adv        = !out_vld_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_lik_r, out_dist_r};
  assign out_tuser  = out_sing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= mlk_pkg::SCALE_RST;
    end else if (cfg_wr_en) begin
      gain_r <= cfg_wr_data;
    end
  end

  // stage 1: differences, determinant products
  logic signed [31:0] pred_x, pred_y, meas_x, meas_y, cov_xx, cov_xy, cov_yx, cov_yy;
  assign pred_x = in_tdata[31:0];
  assign pred_y = in_tdata[63:32];
  assign meas_x = in_tdata[95:64];
  assign meas_y = in_tdata[127:96];
  assign cov_xx = in_tdata[159:128];
  assign cov_xy = in_tdata[191:160];
  assign cov_yx = in_tdata[223:192];
  assign cov_yy = in_tdata[255:224];

  logic s1_vld_r;
  logic signed [32:0] s1_dx_r, s1_dy_r, s1_cxs_r;
  logic signed [31:0] s1_cxx_r, s1_cyy_r;
  logic signed [63:0] s1_da_r, s1_db_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (adv) s1_vld_r <= in_tvalid;
    if (adv) begin
      s1_dx_r  <= 33'(pred_x) - 33'(meas_x);
      s1_dy_r  <= 33'(pred_y) - 33'(meas_y);
      s1_cxs_r <= 33'(cov_xy) + 33'(cov_yx);
      s1_cxx_r <= cov_xx;
      s1_cyy_r <= cov_yy;
      s1_da_r  <= 64'(cov_xx) * 64'(cov_yy);
      s1_db_r  <= 64'(cov_xy) * 64'(cov_yx);
    end
  end

  // stage 2: quadratic products, determinant
  logic s2_vld_r;
  logic signed [65:0] s2_sxx_r, s2_sxy_r, s2_syy_r;
  logic signed [64:0] s2_det_r;
  logic signed [32:0] s2_cxs_r;
  logic signed [31:0] s2_cxx_r, s2_cyy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (adv) s2_vld_r <= s1_vld_r;
    if (adv) begin
      s2_sxx_r <= 66'(s1_dx_r) * 66'(s1_dx_r);
      s2_sxy_r <= 66'(s1_dx_r) * 66'(s1_dy_r);
      s2_syy_r <= 66'(s1_dy_r) * 66'(s1_dy_r);
      s2_det_r <= 65'(s1_da_r) - 65'(s1_db_r);
      s2_cxs_r <= s1_cxs_r;
      s2_cxx_r <= s1_cxx_r;
      s2_cyy_r <= s1_cyy_r;
    end
  end

  // stage 3: coefficient times product, split at bit 33
  logic s3_vld_r;
  logic signed [66:0] s3_al_r, s3_bl_r, s3_cl_r;
  logic signed [65:0] s3_ah_r, s3_bh_r, s3_ch_r;
  logic signed [64:0] s3_det_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (adv) s3_vld_r <= s2_vld_r;
    if (adv) begin
      s3_al_r  <= 67'(s2_cyy_r) * 67'($signed({1'b0, s2_sxx_r[32:0]}));
      s3_ah_r  <= 66'(s2_cyy_r) * 66'($signed(s2_sxx_r[65:33]));
      s3_bl_r  <= 67'(s2_cxs_r) * 67'($signed({1'b0, s2_sxy_r[32:0]}));
      s3_bh_r  <= 66'(s2_cxs_r) * 66'($signed(s2_sxy_r[65:33]));
      s3_cl_r  <= 67'(s2_cxx_r) * 67'($signed({1'b0, s2_syy_r[32:0]}));
      s3_ch_r  <= 66'(s2_cxx_r) * 66'($signed(s2_syy_r[65:33]));
      s3_det_r <= s2_det_r;
    end
  end

  // stage 4: numerator of the quadratic form
  logic signed [99:0] t_a, t_b, t_c;
  always_comb begin
    t_a = (100'(s3_ah_r) <<< 33) + 100'(s3_al_r);
    t_b = (100'(s3_bh_r) <<< 33) + 100'(s3_bl_r);
    t_c = (100'(s3_ch_r) <<< 33) + 100'(s3_cl_r);
  end

  logic s4_vld_r;
  logic signed [99:0] s4_num_r;
  logic signed [64:0] s4_det_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (adv) s4_vld_r <= s3_vld_r;
    if (adv) begin
      s4_num_r <= t_a - t_b + t_c;
      s4_det_r <= s3_det_r;
    end
  end

  // stage 5: magnitudes, sign cases, scale partial products
  logic [99:0] anum;
  logic [64:0] aden;
  logic [23:0] kscale;
  logic nneg, dneg;
  always_comb begin
    nneg   = s4_num_r[99];
    dneg   = s4_det_r[64];
    anum   = nneg ? 100'(-s4_num_r) : 100'(s4_num_r);
    aden   = dneg ? 65'(-s4_det_r) : 65'(s4_det_r);
    kscale = {gain_r, 8'd0};
  end

  logic s5_vld_r, s5_sing_r, s5_sat_r;
  logic [56:0] s5_p0_r, s5_p1_r, s5_p2_r;
  logic [64:0] s5_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else if (adv) s5_vld_r <= s4_vld_r;
    if (adv) begin
      s5_sing_r <= s4_det_r == '0;
      s5_sat_r  <= (s4_num_r != '0) && (nneg != dneg);
      s5_p0_r   <= 57'(anum[32:0]) * 57'(kscale);
      s5_p1_r   <= 57'(anum[65:33]) * 57'(kscale);
      s5_p2_r   <= 57'(anum[98:66]) * 57'(kscale);
      s5_den_r  <= aden;
    end
  end

  // stage 6: scaled numerator, overflow check, divider load
  logic [127:0] scaled;
  assign scaled = 128'(s5_p0_r) + (128'(s5_p1_r) << 33) + (128'(s5_p2_r) << 66);

  localparam int unsigned DS = mlk_pkg::DIV_STAGES;
  logic        dv_vld_r  [0:DS];
  logic        dv_sat_r  [0:DS];
  logic        dv_sing_r [0:DS];
  logic [64:0] dv_rem_r  [0:DS];
  logic [63:0] dv_lo_r   [0:DS];
  logic [63:0] dv_q_r    [0:DS];
  logic [64:0] dv_den_r  [0:DS];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r[0] <= 1'b0;
    else if (adv) dv_vld_r[0] <= s5_vld_r;
    if (adv) begin
      dv_sing_r[0] <= s5_sing_r;
      dv_sat_r[0]  <= s5_sat_r || (!s5_sing_r && (65'(scaled[127:64]) >= s5_den_r));
      dv_rem_r[0]  <= 65'(scaled[127:64]);
      dv_lo_r[0]   <= scaled[63:0];
      dv_q_r[0]    <= '0;
      dv_den_r[0]  <= s5_den_r;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < DS; i++) begin : g_div
    logic [65:0] rem2;
    logic ge;
    always_comb begin
      rem2 = {dv_rem_r[i], dv_lo_r[i][63]};
      ge   = rem2 >= {1'b0, dv_den_r[i]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[i+1] <= 1'b0;
      else if (adv) dv_vld_r[i+1] <= dv_vld_r[i];
      if (adv) begin
        dv_sat_r[i+1]  <= dv_sat_r[i];
        dv_sing_r[i+1] <= dv_sing_r[i];
        dv_rem_r[i+1]  <= ge ? 65'(rem2 - {1'b0, dv_den_r[i]}) : rem2[64:0];
        dv_lo_r[i+1]   <= {dv_lo_r[i][62:0], 1'b0};
        dv_q_r[i+1]    <= {dv_q_r[i][62:0], ge};
        dv_den_r[i+1]  <= dv_den_r[i];
      end
    end
  end

  // integer square root, one result bit per stage
  localparam int unsigned SS = mlk_pkg::SQRT_STAGES;
  logic        sq_vld_r  [1:SS];
  logic        sq_sat_r  [1:SS];
  logic        sq_sing_r [1:SS];
  logic [63:0] sq_v_r    [1:SS];
  logic [63:0] sq_res_r  [1:SS];

  for (genvar i = 0; i < SS; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic        vld_i, sat_i, sing_i, ge;
    logic [63:0] v_i, res_i, trial;
    if (i == 0) begin : g_first
      always_comb begin
        vld_i = dv_vld_r[DS]; sat_i = dv_sat_r[DS]; sing_i = dv_sing_r[DS];
        v_i = dv_q_r[DS]; res_i = '0;
      end
    end else begin : g_next
      always_comb begin
        vld_i = sq_vld_r[i]; sat_i = sq_sat_r[i]; sing_i = sq_sing_r[i];
        v_i = sq_v_r[i]; res_i = sq_res_r[i];
      end
    end
    always_comb begin
      trial = res_i + BIT;
      ge    = v_i >= trial;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld_r[i+1] <= 1'b0;
      else if (adv) sq_vld_r[i+1] <= vld_i;
      if (adv) begin
        sq_sat_r[i+1]  <= sat_i;
        sq_sing_r[i+1] <= sing_i;
        sq_v_r[i+1]    <= ge ? v_i - trial : v_i;
        sq_res_r[i+1]  <= ge ? (res_i >> 1) + BIT : res_i >> 1;
      end
    end
  end

  // distance and x = d/2 in Q.32; exponent n found one bit per stage
  logic [31:0] dval;
  logic [46:0] xval;
  always_comb begin
    if (sq_sing_r[SS]) dval = '0;
    else if (sq_sat_r[SS]) dval = '1;
    else dval = sq_res_r[SS][31:0];
    xval = {dval, 15'd0};
  end

  localparam int unsigned NB = mlk_pkg::NBITS;
  logic        ex_vld_r  [0:NB];
  logic [46:0] ex_x_r    [0:NB];
  logic [5:0]  ex_n_r    [0:NB];
  logic [31:0] ex_dist_r [0:NB];
  logic        ex_sing_r [0:NB];
  logic        ex_big_r  [0:NB];

  always_ff @(posedge clk) begin
    if (!rst_n) ex_vld_r[0] <= 1'b0;
    else if (adv) ex_vld_r[0] <= sq_vld_r[SS];
    if (adv) begin
      ex_x_r[0]    <= xval;
      ex_n_r[0]    <= '0;
      ex_dist_r[0] <= dval;
      ex_sing_r[0] <= sq_sing_r[SS];
      ex_big_r[0]  <= xval >= mlk_pkg::X_BIG;
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_exp_n
    localparam logic [46:0] STEP = 47'(mlk_pkg::LN2_Q32) << (NB - 1 - j);
    logic ge;
    assign ge = ex_x_r[j] >= STEP;
    always_ff @(posedge clk) begin
      if (!rst_n) ex_vld_r[j+1] <= 1'b0;
      else if (adv) ex_vld_r[j+1] <= ex_vld_r[j];
      if (adv) begin
        ex_x_r[j+1]    <= ge ? ex_x_r[j] - STEP : ex_x_r[j];
        ex_n_r[j+1]    <= {ex_n_r[j][4:0], ge};
        ex_dist_r[j+1] <= ex_dist_r[j];
        ex_sing_r[j+1] <= ex_sing_r[j];
        ex_big_r[j+1]  <= ex_big_r[j];
      end
    end
  end

  // Taylor series for exp(-r); first term needs no multiply
  localparam int unsigned TO = mlk_pkg::TAYLOR_ORD;
  logic                tk_vld_r  [1:TO];
  logic [31:0]         tk_term_r [1:TO];
  mlk_pkg::tk_pay_t    tk_pay_r  [1:TO];

  always_ff @(posedge clk) begin
    if (!rst_n) tk_vld_r[1] <= 1'b0;
    else if (adv) tk_vld_r[1] <= ex_vld_r[NB];
    if (adv) begin
      tk_term_r[1]     <= ex_x_r[NB][31:0];
      tk_pay_r[1].r    <= ex_x_r[NB][31:0];
      tk_pay_r[1].sum  <= $signed(34'h1_0000_0000) - $signed({2'b00, ex_x_r[NB][31:0]});
      tk_pay_r[1].n    <= ex_n_r[NB];
      tk_pay_r[1].dval <= ex_dist_r[NB];
      tk_pay_r[1].sing <= ex_sing_r[NB];
      tk_pay_r[1].big  <= ex_big_r[NB];
    end
  end

  for (genvar k = 2; k <= TO; k++) begin : g_tk
    localparam int unsigned KV    = k;
    localparam logic [34:0] RECIP = 35'((64'd1 << mlk_pkg::RECIP_SH) / KV);
    localparam bit          ODD   = (k % 2) == 1;

    logic             a_vld_r, b_vld_r;
    logic [31:0]      a_p_r, b_p_r, b_qe_r;
    mlk_pkg::tk_pay_t a_pay_r, b_pay_r, pay_nxt;
    logic [63:0]      prod;
    logic [66:0]      prod2;
    logic [35:0]      qk;
    logic [31:0]      rem, q;
    logic signed [33:0] sum_nxt;

    always_comb begin
      prod  = 64'(tk_term_r[k-1]) * 64'(tk_pay_r[k-1].r);
      prod2 = 67'(a_p_r) * 67'(RECIP);
      qk    = 36'(b_qe_r) * 36'(KV);
      rem   = b_p_r - qk[31:0];
      // estimate is low by at most one
      q     = (rem >= 32'(KV)) ? b_qe_r + 32'd1 : b_qe_r;
      if (ODD) sum_nxt = b_pay_r.sum - $signed({2'b00, q});
      else sum_nxt = b_pay_r.sum + $signed({2'b00, q});
      pay_nxt     = b_pay_r;
      pay_nxt.sum = sum_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r     <= 1'b0;
        b_vld_r     <= 1'b0;
        tk_vld_r[k] <= 1'b0;
      end else if (adv) begin
        a_vld_r     <= tk_vld_r[k-1];
        b_vld_r     <= a_vld_r;
        tk_vld_r[k] <= b_vld_r;
      end
      if (adv) begin
        a_p_r   <= prod[63:32];
        a_pay_r <= tk_pay_r[k-1];
        b_p_r   <= a_p_r;
        b_qe_r  <= prod2[66:35];
        b_pay_r <= a_pay_r;
        tk_term_r[k] <= q;
        tk_pay_r[k]  <= pay_nxt;
      end
    end
  end

  // output register: round and scale by 2^-(n+1)
  logic [63:0] acc, shifted;
  always_comb begin
    acc     = {30'd0, tk_pay_r[TO].sum} + (64'd1 << (7'd16 + 7'(tk_pay_r[TO].n)));
    shifted = acc >> (7'd17 + 7'(tk_pay_r[TO].n));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= tk_vld_r[TO];
    if (adv) begin
      out_dist_r <= tk_pay_r[TO].dval;
      out_sing_r <= tk_pay_r[TO].sing;
      out_lik_r  <= (tk_pay_r[TO].big || tk_pay_r[TO].sing) ? 16'd0 : shifted[15:0];
    end
  end

  `MLK_ASSERT_IMP(a_sing_zero, out_tvalid && out_tuser[0], out_tdata == 48'd0, "singular result not zero")
  `MLK_ASSERT_IMP(a_lik_max, out_tvalid, out_tdata[47:32] <= 16'd32768, "likelihood above one half")
  `MLK_ASSERT_IMP(a_far_zero, out_tvalid && (out_tdata[31:0] == 32'hFFFF_FFFF), out_tdata[47:32] == 16'd0, "saturated distance with nonzero likelihood")
  `MLK_ASSERT_IMP(a_ready, !out_tvalid, in_tready, "input blocked with empty output")

endmodule

@@ bench/tb_mahalanobis_likelihood_2d.sv @@
`timescale 1ns / 1ps
module tb_mahalanobis_likelihood_2d;

  typedef struct {
    logic signed [31:0] px, py, mx, my, cxx, cxy, cyx, cyy;
  } track_item_t;

  typedef struct {
    logic [31:0] dval;
    logic [15:0] lik;
    logic        sing;
  } gate_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_wr_en = 1'b0;
  logic [15:0]  cfg_wr_data = '0;

  track_item_t  pending_items[$];
  gate_result_t expected_gates[$];
  logic [15:0]  scale_mirror = mlk_pkg::SCALE_RST;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  logic         rx_hold = 1'b0;
  logic         hold_go = 1'b0;
  int           mismatches = 0;

  mahalanobis_likelihood_2d u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // signed coefficient times unsigned magnitude, 128-bit two's complement
  function automatic logic [127:0] wide_term(longint coef, logic [63:0] m, bit neg);
    logic [127:0] r;
    r = {64'd0, mag(coef)} * {64'd0, m};
    return ((coef < 0) != neg) ? -r : r;
  endfunction

  function automatic logic [31:0] root64(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  // 0.5*exp(-d/2): range reduction by ln2, then a 10th order series
  function automatic logic [15:0] chi2_pdf(logic [31:0] d);
    logic [63:0] x, n, r, trm;
    longint sum;
    x = {32'd0, d} << 15;
    n = x / {32'd0, mlk_pkg::LN2_Q32};
    r = x - n * {32'd0, mlk_pkg::LN2_Q32};
    trm = 64'd1 << 32;
    sum = 64'sd1 <<< 32;
    if (n > mlk_pkg::N_MAX) return 16'd0;
    for (int k = 1; k <= mlk_pkg::TAYLOR_ORD; k++) begin
      trm = ((trm * r) >> 32) / k;
      if (k % 2 == 1) sum = sum - longint'(trm);
      else sum = sum + longint'(trm);
    end
    return 16'((64'(sum) + (64'd1 << (16 + n))) >> (17 + n));
  endfunction

  function automatic gate_result_t predict_gate(track_item_t it, logic [15:0] scale);
    gate_result_t g;
    longint dx, dy;
    logic [63:0] adx, ady, k;
    logic [127:0] num, det, anum, aden, v;
    bit nneg, dneg;
    dx = longint'(it.px) - longint'(it.mx);
    dy = longint'(it.py) - longint'(it.my);
    adx = mag(dx);
    ady = mag(dy);
    num = wide_term(longint'(it.cyy), adx * adx, 0)
        + wide_term(longint'(it.cxy) + longint'(it.cyx), adx * ady, (dx < 0) == (dy < 0))
        + wide_term(longint'(it.cxx), ady * ady, 0);
    det = wide_term(longint'(it.cxx) * longint'(it.cyy), 64'd1, 0)
        + wide_term(longint'(it.cxy) * longint'(it.cyx), 64'd1, 1);
    g.sing = 1'b0;
    if (det == 0) begin
      g.dval = 0; g.lik = 0; g.sing = 1'b1;
      return g;
    end
    dneg = det[127];
    nneg = num[127];
    aden = dneg ? -det : det;
    anum = nneg ? -num : num;
    if (anum == 0) begin
      g.dval = 0;
    end else if (nneg != dneg) begin
      g.dval = 32'hFFFF_FFFF; g.lik = 0;
      return g;
    end else begin
      k = {48'd0, scale} << 8;
      v = (anum * {64'd0, k}) / aden;
      g.dval = (v[127:64] != 0) ? 32'hFFFF_FFFF : root64(v[63:0]);
    end
    g.lik = chi2_pdf(g.dval);
    return g;
  endfunction

  function automatic logic signed [31:0] rnd32();
    return $urandom;
  endfunction

  function automatic track_item_t random_track();
    track_item_t it;
    int unsigned mode, a, b;
    mode = $urandom_range(9);
    it.px = rnd32(); it.py = rnd32(); it.mx = rnd32(); it.my = rnd32();
    it.cxx = rnd32(); it.cxy = rnd32(); it.cyx = rnd32(); it.cyy = rnd32();
    if (mode >= 2) begin
      // plausible track: measurement near the prediction
      it.px = rnd32() >>> $urandom_range(0, 16);
      it.py = rnd32() >>> $urandom_range(0, 16);
      it.mx = it.px + (rnd32() >>> $urandom_range(6, 28));
      it.my = it.py + (rnd32() >>> $urandom_range(6, 28));
      it.cxx = $urandom_range(1, 1 << 22);
      it.cyy = $urandom_range(1, 1 << 22);
      it.cxy = rnd32() >>> $urandom_range(12, 31);
      it.cyx = ($urandom_range(3) == 0) ? (rnd32() >>> $urandom_range(12, 31)) : it.cxy;
    end
    if (mode == 8) begin
      // rank one covariance
      a = $urandom_range(0, 1 << 15);
      b = $urandom_range(0, 1 << 15);
      it.cxx = a * a; it.cyy = b * b; it.cxy = a * b; it.cyx = a * b;
    end else if (mode == 9) begin
      it.cyy = -it.cyy;
    end
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) begin
        expected_gates.push_back(predict_gate(pending_items.pop_front(), scale_mirror));
      end
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= {pending_items[0].cyy, pending_items[0].cyx, pending_items[0].cxy,
                     pending_items[0].cxx, pending_items[0].my, pending_items[0].mx,
                     pending_items[0].py, pending_items[0].px};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    gate_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_gates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%b", out_tdata, out_tuser);
      end else begin
        e = expected_gates.pop_front();
        if (out_tdata[31:0] !== e.dval || out_tdata[47:32] !== e.lik
            || out_tuser[0] !== e.sing) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp dist %h lik %h sing %b, got dist %h lik %h sing %b",
                     e.dval, e.lik, e.sing, out_tdata[31:0], out_tdata[47:32], out_tuser[0]);
        end
      end
    end
    out_tready <= rst_n && !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off so the pipe fills and backs up the input
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  task automatic drain();
    while (pending_items.size() > 0 || expected_gates.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_scale(logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scale_mirror = v;
  endtask

  task automatic run_phase(logic [15:0] scale, int unsigned sidle, int unsigned rstall,
                           int n);
    drain();
    write_scale(scale);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (n) pending_items.push_back(random_track());
  endtask

  task automatic add_track(logic signed [31:0] px, py, mx, my, cxx, cxy, cyx, cyy);
    track_item_t it;
    it.px = px; it.py = py; it.mx = mx; it.my = my;
    it.cxx = cxx; it.cxy = cxy; it.cyx = cyx; it.cyy = cyy;
    pending_items.push_back(it);
  endtask

  localparam logic signed [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'h8000_0000;
  localparam logic signed [31:0] ONE  = 32'h0001_0000;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    // directed items at reset scale
    add_track(0, 0, 0, 0, ONE, 0, 0, ONE);                 // zero form
    add_track(0, 0, 0, 0, 0, 0, 0, 0);                     // singular, all zero
    add_track(ONE, ONE, 0, 0, ONE, ONE, ONE, ONE);         // singular, rank one
    add_track(ONE, 0, 0, 0, ONE, 0, 0, -ONE);              // indefinite along y
    add_track(0, ONE, 0, 0, ONE, 0, 0, -ONE);              // indefinite, other sign
    add_track(MAXV, MAXV, MINV, MINV, 1, 0, 0, 1);         // huge distance saturates
    add_track(MINV, MINV, MAXV, MAXV, MAXV, 0, 0, MAXV);
    add_track(MAXV, MINV, MINV, MAXV, MINV, MAXV, MAXV, MINV);
    add_track(-1, -1, -1, -1, -1, -1, -1, -1);
    add_track(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    add_track(ONE, 0, 0, 0, ONE, 0, 0, ONE);               // d = 1
    add_track(32'sd1, 0, 0, 0, ONE, 0, 0, ONE);            // tiny offset
    add_track(4 * ONE, 3 * ONE, 0, 0, ONE, 0, 0, ONE);
    add_track(100 * ONE, 0, 0, 0, ONE, 0, 0, ONE);         // exponent range ends
    add_track(ONE, ONE, 0, 0, 2 * ONE, ONE, -ONE, 2 * ONE);
    add_track(-ONE, ONE, 0, 0, -ONE, 0, 0, -ONE);          // negative definite
    add_track(MINV, 0, MAXV, 0, MINV, 0, 0, MAXV);
    add_track(0, 0, 0, 0, MINV, MINV, MINV, MINV);
    run_phase(16'hFFFF, 0, 0, 20);
    pending_items.push_back(pending_items[0]);
    run_phase(16'd0, 0, 0, 10);
    run_phase(16'd256, 0, 0, 300);
    run_phase(16'd1, 67, 0, 300);
    run_phase(16'hFFFF, 0, 67, 300);
    run_phase(16'($urandom), 21, 21, 300);
    run_phase(16'd0, 67, 67, 100);
    run_phase(16'd512, 0, 0, 400);
    hold_go <= 1'b1;
    run_phase(16'($urandom), 21, 21, 300);
    drain();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/mlk_pkg.sv
src/mahalanobis_likelihood_2d.sv
bench/tb_mahalanobis_likelihood_2d.sv
